>>> design/pau_pkg.sv
// Shared types, constants and gain tables for the packed ADC unpacker with AGC.
package pau_pkg;

  localparam int SAMPLES_PER_ITEM = 8;
  localparam int GAIN_STEPS       = 22;
  localparam int RAW_W            = 12;
  localparam int SQ_W             = 23;
  localparam int BLOCK_E_W        = 26;
  localparam int ENERGY_W         = 48;
  localparam int COUNT_W          = 25;
  localparam int WINDOW_W         = 24;
  localparam int THRESH_W         = 47;
  localparam int STEP_W           = 5;
  localparam int TOTAL_W          = 6;
  localparam int OVER_W           = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 47;
  localparam int IN_DATA_W        = 96;
  localparam int OUT_DATA_W       = 112;

  localparam logic [CFG_IDX_W-1:0] REG_AGC_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINEARITY_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_WINDOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_CEIL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP     = 3'd5;

  localparam logic [STEP_W-1:0]   STEP_MAX        = STEP_W'(GAIN_STEPS - 1);
  localparam logic [RAW_W-1:0]    RAW_FULL_SCALE  = 12'hfff;
  localparam logic [RAW_W-1:0]    RAW_NEG_LIMIT   = 12'd1;
  localparam logic [COUNT_W:0]    BLOCK_SAMPLES   = (COUNT_W+1)'(SAMPLES_PER_ITEM);
  localparam logic [ENERGY_W-1:0] ENERGY_SAT      = '1;
  localparam logic [COUNT_W-1:0]  COUNT_SAT       = '1;

  localparam logic [TOTAL_W-1:0] LIN_TOTAL [GAIN_STEPS] = '{
    6'd39, 6'd38, 6'd36, 6'd33, 6'd31, 6'd28, 6'd26, 6'd25, 6'd23, 6'd19, 6'd18,
    6'd17, 6'd15, 6'd13, 6'd13, 6'd12, 6'd10, 6'd9,  6'd8,  6'd7,  6'd5,  6'd4};
  localparam logic [TOTAL_W-1:0] SENS_TOTAL [GAIN_STEPS] = '{
    6'd39, 6'd38, 6'd37, 6'd36, 6'd34, 6'd32, 6'd31, 6'd29, 6'd28, 6'd26, 6'd24,
    6'd21, 6'd18, 6'd17, 6'd15, 6'd13, 6'd12, 6'd10, 6'd7,  6'd6,  6'd5,  6'd4};

  typedef struct packed {
    logic signed [RAW_W-1:0] sample;
    logic                    over;
    logic [SQ_W-1:0]         square;
  } lane_out_t;

  typedef struct packed {
    logic [SAMPLES_PER_ITEM-1:0][RAW_W-1:0] samples;
    logic [BLOCK_E_W-1:0]                   energy;
    logic [OVER_W-1:0]                      over_count;
  } merge_out_t;

  function automatic logic [TOTAL_W-1:0] gain_total(input logic mode,
                                                    input logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] row;
    row = STEP_MAX - step;
    return mode ? LIN_TOTAL[row] : SENS_TOTAL[row];
  endfunction

endpackage

>>> design/pau_lane.sv
// One sample lane: offset-binary to signed, overrange flag and square.
module pau_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pau_pkg::RAW_W-1:0]  raw,
  output pau_pkg::lane_out_t         lane
);
  import pau_pkg::*;

  logic signed [RAW_W-1:0]   x;
  logic signed [2*RAW_W-1:0] prod;

  assign x    = signed'({~raw[RAW_W-1], raw[RAW_W-2:0]});
  assign prod = x * x;

  always_ff @(posedge clk) begin
    if (en) begin
      lane.sample <= x;
      lane.over   <= (raw == RAW_FULL_SCALE) || (raw <= RAW_NEG_LIMIT);
      lane.square <= prod[SQ_W-1:0];
    end
  end

endmodule

>>> design/pau_merge.sv
// Merge stage: block energy and overrange count across the lanes.
module pau_merge (
  input  logic                clk,
  input  logic                en,
  input  pau_pkg::lane_out_t  lanes [pau_pkg::SAMPLES_PER_ITEM],
  output pau_pkg::merge_out_t blk
);
  import pau_pkg::*;

  logic [BLOCK_E_W-1:0] energy;
  logic [OVER_W-1:0]    over;

  always_comb begin
    energy = '0;
    over   = '0;
    for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
      energy = energy + BLOCK_E_W'(lanes[i].square);
      over   = over + OVER_W'(lanes[i].over);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
        blk.samples[i] <= lanes[i].sample;
      end
      blk.energy     <= energy;
      blk.over_count <= over;
    end
  end

endmodule

>>> design/pau_agc.sv
// Configuration registers, window energy integration, gain stepping, result register.
module pau_agc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [pau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pau_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              en,
  input  pau_pkg::merge_out_t               blk,
  output logic [pau_pkg::OUT_DATA_W-1:0]    result
);
  import pau_pkg::*;

  logic                agc_enable;
  logic                linearity_mode;
  logic [WINDOW_W-1:0] agc_window;
  logic [THRESH_W-1:0] energy_floor;
  logic [THRESH_W-1:0] energy_ceil;

  logic [ENERGY_W-1:0] energy_sum;
  logic [COUNT_W-1:0]  window_count;
  logic [STEP_W-1:0]   gain_step;

  logic [ENERGY_W:0]   energy_add;
  logic [ENERGY_W-1:0] energy_sat;
  logic [COUNT_W:0]    count_add;
  logic [COUNT_W-1:0]  count_sat;
  logic                eval;
  logic [ENERGY_W-1:0] energy_sum_next;
  logic [COUNT_W-1:0]  window_count_next;
  logic [STEP_W-1:0]   gain_step_next;
  logic [STEP_W-1:0]   start_step;

  assign energy_add = {1'b0, energy_sum} + (ENERGY_W+1)'(blk.energy);
  assign energy_sat = energy_add[ENERGY_W] ? ENERGY_SAT : energy_add[ENERGY_W-1:0];
  assign count_add  = {1'b0, window_count} + BLOCK_SAMPLES;
  assign count_sat  = count_add[COUNT_W] ? COUNT_SAT : count_add[COUNT_W-1:0];
  assign eval       = agc_enable && (count_sat >= COUNT_W'(agc_window));
  assign start_step = (cfg_data[STEP_W-1:0] > STEP_MAX) ? STEP_MAX : cfg_data[STEP_W-1:0];

  always_comb begin
    energy_sum_next   = energy_sum;
    window_count_next = window_count;
    gain_step_next    = gain_step;
    if (agc_enable) begin
      energy_sum_next   = energy_sat;
      window_count_next = count_sat;
      if (eval) begin
        energy_sum_next   = '0;
        window_count_next = '0;
        if (energy_sat < ENERGY_W'(energy_floor)) begin
          if (gain_step != STEP_MAX) gain_step_next = gain_step + 1'b1;
        end else if (energy_sat > ENERGY_W'(energy_ceil)) begin
          if (gain_step != '0) gain_step_next = gain_step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agc_enable     <= 1'b1;
      linearity_mode <= 1'b0;
      agc_window     <= WINDOW_W'(1000000);
      energy_floor   <= THRESH_W'(64'd419430400);
      energy_ceil    <= THRESH_W'(64'd419430400000);
      energy_sum     <= '0;
      window_count   <= '0;
      gain_step      <= STEP_MAX;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_AGC_ENABLE:     agc_enable     <= cfg_data[0];
          REG_LINEARITY_MODE: linearity_mode <= cfg_data[0];
          REG_AGC_WINDOW:     agc_window     <= cfg_data[WINDOW_W-1:0];
          REG_ENERGY_FLOOR:   energy_floor   <= cfg_data[THRESH_W-1:0];
          REG_ENERGY_CEIL:    energy_ceil    <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        energy_sum   <= energy_sum_next;
        window_count <= window_count_next;
      end
      if (cfg_valid && cfg_index == REG_START_STEP) begin
        gain_step <= start_step;
      end else if (en) begin
        gain_step <= gain_step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= {gain_step_next != gain_step,
                 gain_total(linearity_mode, gain_step_next),
                 gain_step_next,
                 blk.over_count,
                 blk.samples};
    end
  end

endmodule

>>> design/packed_adc_unpack_agc.sv
// Top level: packed 12-bit ADC sample unpacker with stepped software AGC.
// An accepted input word passes the lane, merge and AGC result registers to the result word on m_tvalid.
// Throughput: one word per cycle while m_tready is not held low, set by the lane, merge and AGC register stages.
// The energy add, saturation and threshold compare are combinational ahead of the AGC registers.
// Reset (rst, synchronous): pipeline emptied, energy and window count cleared,
// gain step 21, registers back to their default values.
module packed_adc_unpack_agc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // packed_word_a [31:0], packed_word_b [63:32], packed_word_c [95:64]
  input  logic [pau_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // sample_zero..sample_seven 12 bits each [95:0], overrange_count [99:96],
  // current_gain_step [104:100], total_gain [110:105], gain_changed [111]
  output logic [pau_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pau_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pau_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pau_pkg::*;

  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [RAW_W-1:0] raw [SAMPLES_PER_ITEM];
  lane_out_t  lanes [SAMPLES_PER_ITEM];
  merge_out_t blk;

  logic lane_valid;
  logic merge_valid;
  logic adv_merge;
  logic adv_out;
  logic load_out;

  assign word_a = s_tdata[31:0];
  assign word_b = s_tdata[63:32];
  assign word_c = s_tdata[95:64];

  assign raw[0] = word_a[31:20];
  assign raw[1] = word_a[19:8];
  assign raw[2] = {word_a[7:0], word_b[31:28]};
  assign raw[3] = word_b[27:16];
  assign raw[4] = word_b[15:4];
  assign raw[5] = {word_b[3:0], word_c[31:24]};
  assign raw[6] = word_c[23:12];
  assign raw[7] = word_c[11:0];

  assign adv_out   = !m_tvalid || m_tready;
  assign adv_merge = !merge_valid || adv_out;
  assign s_tready  = !lane_valid || adv_merge;
  assign load_out  = merge_valid && adv_out;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid  <= 1'b0;
      merge_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready)  lane_valid  <= s_tvalid;
      if (adv_merge) merge_valid <= lane_valid;
      if (adv_out)   m_tvalid    <= merge_valid;
    end
  end

  for (genvar i = 0; i < SAMPLES_PER_ITEM; i++) begin : g_lane
    pau_lane u_lane (
      .clk  (clk),
      .en   (s_tready),
      .raw  (raw[i]),
      .lane (lanes[i])
    );
  end

  pau_merge u_merge (
    .clk   (clk),
    .en    (adv_merge),
    .lanes (lanes),
    .blk   (blk)
  );

  pau_agc u_agc (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .en        (load_out),
    .blk       (blk),
    .result    (m_tdata)
  );

endmodule
